FILE: hdl/rgbgb_pkg.sv
// shared types, constants and the srgb conversion tables for the gradient blend core
package rgbgb_pkg;

    localparam int STEP_FRAC_BITS_DEF = 8;
    localparam int COLOR_W            = 24;
    localparam int STEP_W             = 11;
    localparam int CH_W               = 8;
    localparam int NUM_CH             = 3;
    localparam int TAB_DEPTH          = 256;
    localparam int CH_MAX             = 255;
    localparam int LIN_FIRST_NZ       = 11;
    localparam int SRGB_DEN           = 10761;
    localparam int SRGB_MUL           = 40;
    localparam int SRGB_OFS           = 561;
    localparam int POW_NUM            = 5;
    localparam int POW_DEN            = 12;
    localparam int BIG_W              = 256;

    typedef logic [NUM_CH-1:0][CH_W-1:0]    t_chans;
    typedef logic [TAB_DEPTH-1:0][CH_W-1:0] t_tab;
    typedef logic [BIG_W-1:0]               t_big;

    typedef struct packed {
        logic valid;
        logic gamma;
    } t_ctrl;

    // a * m^e in wide integer arithmetic, evaluated at elaboration only
    function automatic t_big big_mulpow(t_big a, int unsigned m, int unsigned e);
        t_big r;
        r = a;
        for (int unsigned n = 0; n < e; n++) begin
            r = r * t_big'(m);
        end
        return r;
    endfunction

    // k <= 255 * ((40c+561)/10761)^2.4
    function automatic bit lin_ok(int unsigned k, int unsigned c);
        t_big l;
        t_big r;
        l = big_mulpow(big_mulpow(t_big'(1), k, POW_NUM), SRGB_DEN, POW_DEN);
        r = big_mulpow(big_mulpow(t_big'(1), CH_MAX, POW_NUM),
                       SRGB_MUL * c + SRGB_OFS, POW_DEN);
        return (l <= r);
    endfunction

    // (40k+561)^12 * 255^5 <= c^5 * 10761^12
    function automatic bit enc_ok(int unsigned k, int unsigned c);
        t_big l;
        t_big r;
        l = big_mulpow(big_mulpow(t_big'(1), SRGB_MUL * k + SRGB_OFS, POW_DEN),
                       CH_MAX, POW_NUM);
        r = big_mulpow(big_mulpow(t_big'(1), c, POW_NUM), SRGB_DEN, POW_DEN);
        return (l <= r);
    endfunction

    function automatic t_tab build_lin();
        t_tab        tab;
        int unsigned k;
        k = 0;
        for (int unsigned c = 0; c < TAB_DEPTH; c++) begin
            if (c >= LIN_FIRST_NZ) begin
                while (k < CH_MAX && lin_ok(k + 1, c)) begin
                    k++;
                end
            end
            tab[c] = CH_W'(k);
        end
        return tab;
    endfunction

    function automatic t_tab build_enc();
        t_tab        tab;
        int unsigned k;
        k = 0;
        tab[0] = '0;
        for (int unsigned c = 1; c < TAB_DEPTH; c++) begin
            while (k < CH_MAX && enc_ok(k + 1, c)) begin
                k++;
            end
            tab[c] = CH_W'(k);
        end
        return tab;
    endfunction

    localparam t_tab LIN_TAB = build_lin();
    localparam t_tab ENC_TAB = build_enc();

endpackage

FILE: hdl/rgb_gradient_blend_core.sv
// top level of the rgb gradient blend core
//
// Blends two packed RGB colors channel by channel with a signed fixed-point step
// clamped to 0..1, optionally in linear light through srgb decode/encode tables.
// A transaction is taken on every clock where start is high; busy is never raised,
// so one color per clock is sustained without gaps. Each result appears on
// o_blended_color marked by a one-cycle o_valid, in input order, after passing
// through the four register stages: clamp and linearize, multiply, sum and
// scale, encode. The receiver cannot stall the core and must take every result
// in the cycle it is shown.
module rgb_gradient_blend_core #(
    parameter int STEP_FRAC_BITS = rgbgb_pkg::STEP_FRAC_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [rgbgb_pkg::COLOR_W-1:0]       i_from_color,
    input  logic [rgbgb_pkg::COLOR_W-1:0]       i_to_color,
    input  logic signed [rgbgb_pkg::STEP_W-1:0] i_blend_step,
    input  logic                                i_gamma_mode,
    output logic                                o_valid,
    output logic [rgbgb_pkg::COLOR_W-1:0]       o_blended_color
);
    import rgbgb_pkg::*;

    localparam int ONE     = 1 << STEP_FRAC_BITS;
    localparam int LATENCY = 4;

    t_ctrl                    lin_ctrl;
    t_chans                   lin_from_ch;
    t_chans                   lin_to_ch;
    logic [STEP_FRAC_BITS:0]  lin_w_from;
    logic [STEP_FRAC_BITS:0]  lin_w_to;
    t_ctrl                    mix_ctrl;
    t_chans                   mix_ch;
    logic                     accept;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    rgbgb_linearize #(
        .STEP_FRAC_BITS (STEP_FRAC_BITS)
    ) u_linearize (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (accept),
        .i_from_color (i_from_color),
        .i_to_color   (i_to_color),
        .i_blend_step (i_blend_step),
        .i_gamma_mode (i_gamma_mode),
        .o_ctrl       (lin_ctrl),
        .o_from_ch    (lin_from_ch),
        .o_to_ch      (lin_to_ch),
        .o_w_from     (lin_w_from),
        .o_w_to       (lin_w_to)
    );

    rgbgb_mix #(
        .STEP_FRAC_BITS (STEP_FRAC_BITS)
    ) u_mix (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctrl    (lin_ctrl),
        .i_from_ch (lin_from_ch),
        .i_to_ch   (lin_to_ch),
        .i_w_from  (lin_w_from),
        .i_w_to    (lin_w_to),
        .o_ctrl    (mix_ctrl),
        .o_ch      (mix_ch)
    );

    rgbgb_encode u_encode (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ctrl          (mix_ctrl),
        .i_ch            (mix_ch),
        .o_valid         (o_valid),
        .o_blended_color (o_blended_color)
    );

    // a result strobe only ever follows a transaction taken on start
    a_valid_follows_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start, LATENCY))
        else $error("result strobe without matching transaction");

    // the weights must always sum to one
    a_weights_sum_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        lin_ctrl.valid |-> (int'(lin_w_from) + int'(lin_w_to) == ONE))
        else $error("blend weights do not sum to one");

    // raw mode with a step at or below zero returns the start color
    a_low_clamp_raw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !$past(i_gamma_mode, LATENCY)
            && ($past(i_blend_step[STEP_W-1], LATENCY)
                || $past(i_blend_step, LATENCY) == '0))
        |-> o_blended_color == $past(i_from_color, LATENCY))
        else $error("low clamp in raw mode does not return start color");

    if (STEP_FRAC_BITS <= STEP_W - 2) begin : g_high_clamp
        // raw mode with a step at or above one returns the end color
        a_high_clamp_raw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
            (o_valid && !$past(i_gamma_mode, LATENCY)
                && !$past(i_blend_step[STEP_W-1], LATENCY)
                && $unsigned($past(i_blend_step, LATENCY)) >= STEP_W'(ONE))
            |-> o_blended_color == $past(i_to_color, LATENCY))
            else $error("high clamp in raw mode does not return end color");
    end

endmodule

FILE: hdl/rgbgb_linearize.sv
// stage 1: step clamp, blend weights and srgb linearizing lookup
module rgbgb_linearize #(
    parameter int STEP_FRAC_BITS = rgbgb_pkg::STEP_FRAC_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    input  logic [rgbgb_pkg::COLOR_W-1:0]       i_from_color,
    input  logic [rgbgb_pkg::COLOR_W-1:0]       i_to_color,
    input  logic signed [rgbgb_pkg::STEP_W-1:0] i_blend_step,
    input  logic                                i_gamma_mode,
    output rgbgb_pkg::t_ctrl                    o_ctrl,
    output rgbgb_pkg::t_chans                   o_from_ch,
    output rgbgb_pkg::t_chans                   o_to_ch,
    output logic [STEP_FRAC_BITS:0]             o_w_from,
    output logic [STEP_FRAC_BITS:0]             o_w_to
);
    import rgbgb_pkg::*;

    localparam int WW  = STEP_FRAC_BITS + 1;
    localparam int ONE = 1 << STEP_FRAC_BITS;

    t_ctrl          r_ctrl;
    t_chans         r_from_ch, n_from_ch;
    t_chans         r_to_ch, n_to_ch;
    logic [WW-1:0]  r_w_from, n_w_from;
    logic [WW-1:0]  r_w_to, n_w_to;

    always_comb begin
        if (i_blend_step[STEP_W-1]) begin
            n_w_to = '0;
        end else if (int'($unsigned(i_blend_step)) > ONE) begin
            n_w_to = WW'(ONE);
        end else begin
            n_w_to = WW'($unsigned(i_blend_step));
        end
        n_w_from = WW'(ONE) - n_w_to;
    end

    always_comb begin
        for (int i = 0; i < NUM_CH; i++) begin
            if (i_gamma_mode) begin
                n_from_ch[i] = LIN_TAB[i_from_color[CH_W*i +: CH_W]];
                n_to_ch[i]   = LIN_TAB[i_to_color[CH_W*i +: CH_W]];
            end else begin
                n_from_ch[i] = i_from_color[CH_W*i +: CH_W];
                n_to_ch[i]   = i_to_color[CH_W*i +: CH_W];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl <= '0;
        end else begin
            r_ctrl.valid <= i_valid;
            r_ctrl.gamma <= i_gamma_mode;
        end
    end

    always_ff @(posedge i_clk) begin
        r_from_ch <= n_from_ch;
        r_to_ch   <= n_to_ch;
        r_w_from  <= n_w_from;
        r_w_to    <= n_w_to;
    end

    assign o_ctrl    = r_ctrl;
    assign o_from_ch = r_from_ch;
    assign o_to_ch   = r_to_ch;
    assign o_w_from  = r_w_from;
    assign o_w_to    = r_w_to;

endmodule

FILE: hdl/rgbgb_mix.sv
// stages 2 and 3: weighted products, then sum and scale back to 8 bits
module rgbgb_mix #(
    parameter int STEP_FRAC_BITS = rgbgb_pkg::STEP_FRAC_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  rgbgb_pkg::t_ctrl            i_ctrl,
    input  rgbgb_pkg::t_chans           i_from_ch,
    input  rgbgb_pkg::t_chans           i_to_ch,
    input  logic [STEP_FRAC_BITS:0]     i_w_from,
    input  logic [STEP_FRAC_BITS:0]     i_w_to,
    output rgbgb_pkg::t_ctrl            o_ctrl,
    output rgbgb_pkg::t_chans           o_ch
);
    import rgbgb_pkg::*;

    localparam int WW = STEP_FRAC_BITS + 1;
    localparam int PW = CH_W + WW;
    localparam int SW = PW + 1;

    t_ctrl                      r_ctrl2;
    t_ctrl                      r_ctrl3;
    logic [NUM_CH-1:0][PW-1:0]  r_pf, n_pf;
    logic [NUM_CH-1:0][PW-1:0]  r_pt, n_pt;
    logic [NUM_CH-1:0][SW-1:0]  n_sum;
    t_chans                     r_ch, n_ch;

    always_comb begin
        for (int i = 0; i < NUM_CH; i++) begin
            n_pf[i] = PW'(i_from_ch[i]) * PW'(i_w_from);
            n_pt[i] = PW'(i_to_ch[i]) * PW'(i_w_to);
        end
    end

    // convex combination, so the scaled sum always fits in 8 bits
    always_comb begin
        for (int i = 0; i < NUM_CH; i++) begin
            n_sum[i] = SW'(r_pf[i]) + SW'(r_pt[i]);
            n_ch[i]  = n_sum[i][STEP_FRAC_BITS +: CH_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl2 <= '0;
            r_ctrl3 <= '0;
        end else begin
            r_ctrl2 <= i_ctrl;
            r_ctrl3 <= r_ctrl2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pf <= n_pf;
        r_pt <= n_pt;
        r_ch <= n_ch;
    end

    assign o_ctrl = r_ctrl3;
    assign o_ch   = r_ch;

endmodule

FILE: hdl/rgbgb_encode.sv
// stage 4: srgb encoding lookup and output register
module rgbgb_encode (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  rgbgb_pkg::t_ctrl                i_ctrl,
    input  rgbgb_pkg::t_chans               i_ch,
    output logic                            o_valid,
    output logic [rgbgb_pkg::COLOR_W-1:0]   o_blended_color
);
    import rgbgb_pkg::*;

    logic               r_valid;
    logic [COLOR_W-1:0] r_color, n_color;

    always_comb begin
        for (int i = 0; i < NUM_CH; i++) begin
            if (i_ctrl.gamma) begin
                n_color[CH_W*i +: CH_W] = ENC_TAB[i_ch[i]];
            end else begin
                n_color[CH_W*i +: CH_W] = i_ch[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_ctrl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_color <= n_color;
    end

    assign o_valid         = r_valid;
    assign o_blended_color = r_color;

endmodule
